// ===== rtl/sls_pkg.sv =====
// ----------------------------------------------------------------------------
// sls_pkg
// Shared types, codes and helpers of the string literal scanner.
// ----------------------------------------------------------------------------
package sls_pkg;

  localparam int POS_BITS   = 32;
  localparam int SPAN_BITS  = 32;
  localparam int CP_BITS    = 21;
  localparam int KIND_BITS  = 3;
  localparam int OUTQ_DEPTH = 3;

  typedef logic [POS_BITS-1:0]  pos_t;
  typedef logic [SPAN_BITS-1:0] span_t;
  typedef logic [CP_BITS-1:0]   cp_t;
  typedef logic [KIND_BITS-1:0] kind_t;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_BODY = 3'd1;
  localparam logic [2:0] PH_ESC  = 3'd2;
  localparam logic [2:0] PH_HEX1 = 3'd3;
  localparam logic [2:0] PH_HEX2 = 3'd4;

  localparam kind_t K_NONE  = 3'd0;
  localparam kind_t K_OK    = 3'd1;
  localparam kind_t K_BAD   = 3'd2;
  localparam kind_t K_HEX   = 3'd3;
  localparam kind_t K_ESC   = 3'd4;
  localparam kind_t K_UNTRM = 3'd5;

  localparam cp_t CH_QUOTE  = 21'h22;
  localparam cp_t CH_BSLASH = 21'h5C;
  localparam cp_t CH_NL     = 21'h0A;
  localparam cp_t CH_X      = 21'h78;

  typedef struct packed {
    logic [2:0] phase;
    pos_t       position;
    pos_t       literal_start;
    pos_t       escape_begin;
    logic       error_seen;
  } state_t;

  typedef struct packed {
    kind_t kind;
    span_t span_start;
    span_t span_end;
    logic  last;
  } res_t;

  function automatic span_t to_span(pos_t p);
    logic [POS_BITS+SPAN_BITS-1:0] w;
    w = {{SPAN_BITS{1'b0}}, p};
    return w[SPAN_BITS-1:0];
  endfunction

  function automatic logic is_hex(cp_t c);
    return (c >= 21'h30 && c <= 21'h39) || (c >= 21'h61 && c <= 21'h66) ||
           (c >= 21'h41 && c <= 21'h46);
  endfunction

  function automatic logic is_simple_esc(cp_t c);
    logic r;
    case (c) inside
      21'h6E, 21'h74, 21'h72, 21'h5C, 21'h22, 21'h27, 21'h30, 21'h75, 21'h55: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/string_literal_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// string_literal_scanner_unit
// Scans a code point stream for double-quoted string literals with escapes.
//
//   channel  | dir | tdata                         | tuser            | tlast
//   s_axis   | in  | [20:0] code_point             | [0] mode (1=eof) | -
//   m_axis   | out | [31:0] span_start,[63:32] end | [2:0] result_kind| last
//
// One item accepted per cycle while the result queue has room; a result
// passes the input register, then the queue. An item giving two results
// (bad hex then rescanned character) pushes both into the three-entry queue.
// Output stalls back up through the queue and then the input register.
// Reset is synchronous and returns the scanner to idle at position zero.
// ----------------------------------------------------------------------------
module string_literal_scanner_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [20:0] code_point, rest zero
  input  logic [0:0]  s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] span_start, [63:32] span_end
  output logic [2:0]  m_axis_tuser,   // [2:0] result_kind
  output logic        m_axis_tlast
);

  logic            in_valid;
  logic            in_mode;
  sls_pkg::cp_t    in_cp;
  sls_pkg::state_t st;
  sls_pkg::state_t st_next;
  logic [1:0]      res_cnt;
  sls_pkg::res_t   res0;
  sls_pkg::res_t   res1;
  sls_pkg::res_t   m_res;
  logic            fits;
  logic            take;

  sls_step u_step (
    .st         (st),
    .mode       (in_mode),
    .code_point (in_cp),
    .st_next    (st_next),
    .res_cnt    (res_cnt),
    .res0       (res0),
    .res1       (res1)
  );

  sls_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .need    (res_cnt),
    .fits    (fits),
    .push    (take),
    .push0   (res0),
    .push1   (res1),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_res   (m_res)
  );

  assign take          = in_valid && fits;
  assign s_axis_tready = !in_valid || fits;

  assign m_axis_tdata = {m_res.span_end, m_res.span_start};
  assign m_axis_tuser = m_res.kind;
  assign m_axis_tlast = m_res.last;

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode <= s_axis_tuser[0];
      in_cp   <= s_axis_tdata[sls_pkg::CP_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      st       <= '{phase: sls_pkg::PH_IDLE, default: '0};
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (take) begin
        in_valid <= 1'b0;
      end
      if (take) begin
        st <= st_next;
      end
    end
  end

endmodule

// ===== rtl/sls_step.sv =====
// ----------------------------------------------------------------------------
// sls_step
// Next state and up to two results for one registered input item.
// ----------------------------------------------------------------------------
module sls_step (
  input  sls_pkg::state_t st,
  input  logic            mode,
  input  sls_pkg::cp_t    code_point,
  output sls_pkg::state_t st_next,
  output logic [1:0]      res_cnt,
  output sls_pkg::res_t   res0,
  output sls_pkg::res_t   res1
);

  sls_pkg::pos_t   pos1;
  logic            eof;
  logic            berr;
  sls_pkg::state_t bst;
  logic            b_emit;
  sls_pkg::res_t   b_res;

  assign pos1 = st.position + sls_pkg::pos_t'(1);
  assign eof  = mode;
  assign berr = st.error_seen || (st.phase == sls_pkg::PH_HEX1);

  // ordinary character inside the literal body
  always_comb begin
    bst        = st;
    bst.error_seen = berr;
    b_emit     = 1'b0;
    b_res      = '0;
    if (code_point == sls_pkg::CH_QUOTE) begin
      bst.position    = pos1;
      bst.phase       = sls_pkg::PH_IDLE;
      b_emit          = 1'b1;
      b_res.kind      = berr ? sls_pkg::K_BAD : sls_pkg::K_OK;
      b_res.span_start = sls_pkg::to_span(st.literal_start);
      b_res.span_end   = sls_pkg::to_span(pos1);
    end else if (code_point == sls_pkg::CH_BSLASH) begin
      bst.escape_begin = st.position;
      bst.position     = pos1;
      bst.phase        = sls_pkg::PH_ESC;
    end else if (code_point == sls_pkg::CH_NL) begin
      bst.position     = pos1;
      bst.phase        = sls_pkg::PH_IDLE;
      b_emit           = 1'b1;
      b_res.kind       = sls_pkg::K_UNTRM;
      b_res.span_start = sls_pkg::to_span(st.literal_start);
      b_res.span_end   = sls_pkg::to_span(st.position);
    end else begin
      bst.position = pos1;
      bst.phase    = sls_pkg::PH_BODY;
    end
  end

  always_comb begin
    sls_pkg::res_t untrm;
    untrm            = '0;
    untrm.kind       = sls_pkg::K_UNTRM;
    untrm.span_start = sls_pkg::to_span(st.literal_start);
    untrm.span_end   = sls_pkg::to_span(st.position);
    st_next = st;
    res_cnt = 2'd0;
    res0    = '0;
    res1    = '0;
    unique case (st.phase)
      sls_pkg::PH_BODY: begin
        if (eof) begin
          st_next.phase = sls_pkg::PH_IDLE;
          res_cnt = 2'd1;
          res0    = untrm;
        end else begin
          st_next = bst;
          res_cnt = {1'b0, b_emit};
          res0    = b_res;
        end
      end
      sls_pkg::PH_ESC: begin
        if (eof) begin
          st_next.error_seen = 1'b1;
          st_next.phase      = sls_pkg::PH_IDLE;
          res_cnt = 2'd1;
          res0    = untrm;
        end else begin
          st_next.position = pos1;
          if (sls_pkg::is_simple_esc(code_point)) begin
            st_next.phase = sls_pkg::PH_BODY;
          end else if (code_point == sls_pkg::CH_X) begin
            st_next.phase = sls_pkg::PH_HEX1;
          end else begin
            st_next.error_seen = 1'b1;
            st_next.phase      = sls_pkg::PH_BODY;
            res_cnt         = 2'd1;
            res0.kind       = sls_pkg::K_ESC;
            res0.span_start = sls_pkg::to_span(st.escape_begin);
            res0.span_end   = sls_pkg::to_span(pos1);
          end
        end
      end
      sls_pkg::PH_HEX1: begin
        if (eof) begin
          st_next.error_seen = 1'b1;
          st_next.phase      = sls_pkg::PH_IDLE;
          res_cnt = 2'd1;
          res0    = untrm;
        end else if (sls_pkg::is_hex(code_point)) begin
          st_next.position = pos1;
          st_next.phase    = sls_pkg::PH_HEX2;
        end else begin
          st_next         = bst;
          res_cnt         = b_emit ? 2'd2 : 2'd1;
          res0.kind       = sls_pkg::K_HEX;
          res0.span_start = sls_pkg::to_span(st.escape_begin);
          res0.span_end   = sls_pkg::to_span(st.position);
          res1            = b_res;
        end
      end
      sls_pkg::PH_HEX2: begin
        if (eof) begin
          st_next.phase = sls_pkg::PH_IDLE;
          res_cnt = 2'd1;
          res0    = untrm;
        end else if (sls_pkg::is_hex(code_point)) begin
          st_next.position = pos1;
          st_next.phase    = sls_pkg::PH_BODY;
        end else begin
          st_next = bst;
          res_cnt = {1'b0, b_emit};
          res0    = b_res;
        end
      end
      default: begin
        if (!eof && code_point == sls_pkg::CH_QUOTE) begin
          st_next.literal_start = st.position;
          st_next.error_seen    = 1'b0;
          st_next.position      = pos1;
          st_next.phase         = sls_pkg::PH_BODY;
        end else begin
          st_next.position = eof ? st.position : pos1;
          st_next.phase    = sls_pkg::PH_IDLE;
          res_cnt         = 2'd1;
          res0.kind       = sls_pkg::K_NONE;
          res0.span_start = sls_pkg::to_span(st.position);
          res0.span_end   = sls_pkg::to_span(st.position);
        end
      end
    endcase
    res0.last = (res_cnt == 2'd1);
    res1.last = 1'b1;
  end

endmodule

// ===== rtl/sls_outq.sv =====
// ----------------------------------------------------------------------------
// sls_outq
// Three-entry result queue; takes up to two results a cycle when they fit, sends one while m_ready is high.
// ----------------------------------------------------------------------------
module sls_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    need,
  output logic          fits,
  input  logic          push,
  input  sls_pkg::res_t push0,
  input  sls_pkg::res_t push1,
  output logic          m_valid,
  input  logic          m_ready,
  output sls_pkg::res_t m_res
);

  sls_pkg::res_t q [sls_pkg::OUTQ_DEPTH];
  logic [1:0]    level;
  logic [1:0]    level_next;
  logic [1:0]    base;
  logic [1:0]    pcnt;
  logic          pop;

  assign fits    = ({1'b0, level} + {1'b0, need}) <= 3'(sls_pkg::OUTQ_DEPTH);
  assign pop     = (level != 2'd0) && m_ready;
  assign base    = level - {1'b0, pop};
  assign pcnt    = push ? need : 2'd0;
  assign level_next = base + pcnt;
  assign m_valid = (level != 2'd0);
  assign m_res   = q[0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < sls_pkg::OUTQ_DEPTH; i++) begin
      if (pcnt != 2'd0 && base == 2'(i)) begin
        q[i] <= push0;
      end else if (pcnt == 2'd2 && base + 2'd1 == 2'(i)) begin
        q[i] <= push1;
      end else if (pop && i < sls_pkg::OUTQ_DEPTH - 1) begin
        q[i] <= q[(i < sls_pkg::OUTQ_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 2'd0;
    end else begin
      level <= level_next;
    end
  end

endmodule

// ===== rtl/sls_checker.sv =====
// ----------------------------------------------------------------------------
// sls_checker
// Port-level checks of the string literal scanner, bound to the top level.
// ----------------------------------------------------------------------------
module sls_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat after reset");

  a_none_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == sls_pkg::K_NONE |->
      m_axis_tdata[31:0] == m_axis_tdata[63:32])
    else $error("not handled span is not empty");

  a_first_hex: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == sls_pkg::K_HEX)
    else $error("non-final beat is not a bad hex report");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser <= sls_pkg::K_UNTRM)
    else $error("result kind out of range");

endmodule

bind string_literal_scanner_unit sls_checker u_sls_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
